FILE: design/gmc_pkg.sv
// Shared constants, result types and small calendar tables for the
// Gregorian date / MJD converter. No dependencies.
`default_nettype none

package gmc_pkg;

    // Stage count of both conversion pipelines (input to output register).
    localparam int unsigned DEPTH       = 7;
    // Stages that do arithmetic in the date-to-MJD path; the rest only delay.
    localparam int unsigned DATE_STAGES = 3;

    localparam int unsigned MJD_DATE_OFFSET = 678912;
    localparam int unsigned MJD_GC_OFFSET   = 678881;
    localparam int unsigned DAYS_400Y       = 146097;
    localparam int unsigned DAYS_4Y         = 1461;
    localparam int unsigned DAYS_5M         = 153;

    // Reciprocals for constant division; the quotient comes out exact or
    // one low and is corrected by a remainder compare where needed.
    localparam int unsigned DIV100_MUL    = 5243;   // >> 19, exact below 43690
    localparam int unsigned DIV146097_MUL = 29398;  // >> 32
    localparam int unsigned DIV1461_MUL   = 11483;  // >> 24
    localparam int unsigned DIV153_MUL    = 428;    // >> 16
    localparam int unsigned DIV5_MUL      = 205;    // >> 10, exact below 1024

    typedef struct packed {
        logic        ok;
        logic [23:0] mjd;
    } d2m_res_t;

    typedef struct packed {
        logic        zero;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } m2d_res_t;

    // Days in a month, with the leap flag for February.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(30.59 * (mp - 2)) for the shifted month mp = 3..14.
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd3:    off = 9'd30;
            4'd4:    off = 9'd61;
            4'd5:    off = 9'd91;
            4'd6:    off = 9'd122;
            4'd7:    off = 9'd152;
            4'd8:    off = 9'd183;
            4'd9:    off = 9'd214;
            4'd10:   off = 9'd244;
            4'd11:   off = 9'd275;
            4'd12:   off = 9'd305;
            4'd13:   off = 9'd336;
            4'd14:   off = 9'd367;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

FILE: design/gmc_date2mjd.sv
// Date-to-MJD pipeline: date check, leap rule and day count over three
// stages, then a delay line to the common depth. Uses gmc_pkg.
`default_nettype none

module gmc_date2mjd (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [13:0]     year,
    input  wire logic [3:0]      month,
    input  wire logic [4:0]      day,
    output gmc_pkg::d2m_res_t    res
);
    import gmc_pkg::*;

    localparam int unsigned TAPS = DEPTH - DATE_STAGES + 1;

    // stage 1
    logic        early;
    logic [26:0] prod_y;
    logic [26:0] prod_p;
    logic [13:0] year_reg,  year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg,   day_next;
    logic [13:0] yp_reg,    yp_next;
    logic [3:0]  mp_reg,    mp_next;
    logic [7:0]  q100y_reg, q100y_next;
    logic [7:0]  q100p_reg, q100p_next;

    // stage 2
    logic [14:0] hund;
    logic        leap;
    logic [4:0]  len;
    logic        ok_reg,     ok_next;
    logic [24:0] p_reg,      p_next;
    logic [7:0]  q100p2_reg;
    logic [3:0]  mp2_reg;
    logic [4:0]  day2_reg;

    // stage 3 and delay taps
    logic [23:0] sum_next;
    logic [23:0] mjd_tap_reg [TAPS];
    logic        ok_tap_reg  [TAPS];

    // Fold January and February into months 13 and 14 of the year before.
    always_comb
    begin
        early      = (month <= 4'd2);
        year_next  = year;
        month_next = month;
        day_next   = day;
        yp_next    = early ? year - 14'd1 : year;
        mp_next    = early ? month + 4'd12 : month;
        prod_y     = 27'(year) * 27'(DIV100_MUL);
        prod_p     = 27'(yp_next) * 27'(DIV100_MUL);
        q100y_next = prod_y[26:19];
        q100p_next = prod_p[26:19];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            yp_reg    <= yp_next;
            mp_reg    <= mp_next;
            q100y_reg <= q100y_next;
            q100p_reg <= q100p_next;
        end
    end

    // Leap test on the true year, range check, and 1461*y for the day count.
    always_comb
    begin
        hund    = 15'(q100y_reg) * 15'd100;
        leap    = (year_reg[1:0] == 2'd0) &&
                  (({1'b0, year_reg} != hund) || (q100y_reg[1:0] == 2'd0));
        len     = month_len(month_reg, leap);
        ok_next = (year_reg != 14'd0) && (month_reg != 4'd0) && (month_reg <= 4'd12) &&
                  (day_reg != 5'd0) && (day_reg <= len);
        p_next  = 25'(yp_reg) * 25'(DAYS_4Y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg     <= ok_next;
            p_reg      <= p_next;
            q100p2_reg <= q100p_reg;
            mp2_reg    <= mp_reg;
            day2_reg   <= day_reg;
        end
    end

    // Sum the terms modulo 2^24; y/400 comes from (y/100)/4.
    always_comb
    begin
        sum_next = 24'(p_reg[24:2]) + 24'(q100p2_reg[7:2]) - 24'(q100p2_reg)
                 + 24'(month_offset(mp2_reg)) + 24'(day2_reg) - 24'(MJD_DATE_OFFSET);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mjd_tap_reg[0] <= sum_next;
            ok_tap_reg[0]  <= ok_reg;
            for (int i = 1; i < TAPS; i++)
            begin
                mjd_tap_reg[i] <= mjd_tap_reg[i-1];
                ok_tap_reg[i]  <= ok_tap_reg[i-1];
            end
        end
    end

    assign res.ok  = ok_tap_reg[TAPS-1];
    assign res.mjd = mjd_tap_reg[TAPS-1];

endmodule

`default_nettype wire

FILE: design/gmc_mjd2date.sv
// MJD-to-date pipeline: integer calendar method with reciprocal division
// and remainder correction, one step per stage. Uses gmc_pkg.
`default_nettype none

module gmc_mjd2date (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [21:0]     mjd_in,
    output gmc_pkg::m2d_res_t    res
);
    import gmc_pkg::*;

    logic [DEPTH-1:0] zero_reg;

    // stage 1
    logic [22:0] n_next;
    logic [24:0] x1;
    logic [39:0] prod1;
    logic [22:0] n_reg;
    logic [7:0]  q0_reg, q0_next;

    // stage 2
    logic [24:0] x2;
    logic [24:0] qm;
    logic [24:0] r2;
    logic [22:0] n2_reg;
    logic [7:0]  q_reg, q_next;

    // stage 3
    logic [9:0]  t3;
    logic [7:0]  a3;
    logic [24:0] a2_reg, a2_next;

    // stage 4
    logic [37:0] prod4;
    logic [24:0] a2b_reg;
    logic [13:0] y0_reg, y0_next;

    // stage 5
    logic [24:0] rem;
    logic        fix5;
    logic [11:0] rem1;
    logic [13:0] y5_reg, y5_next;
    logic [10:0] b_reg,  b_next;

    // stage 6
    logic [19:0] prod6;
    logic [13:0] y6_reg;
    logic [10:0] b6_reg;
    logic [3:0]  m0_reg, m0_next;

    // stage 7
    logic [10:0] bm;
    logic [10:0] r7;
    logic        fix7;
    logic [10:0] rr;
    logic [3:0]  m1;
    logic [3:0]  m3;
    logic [14:0] prodd;
    logic [13:0] y7_reg, y7_next;
    logic [3:0]  m7_reg, m7_next;
    logic [4:0]  d7_reg, d7_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[DEPTH-2:0], (mjd_in == 22'd0)};
        end
    end

    // Estimate q = 4(n+1) / 146097.
    always_comb
    begin
        n_next  = 23'(mjd_in) + 23'(MJD_GC_OFFSET);
        x1      = {n_next + 23'd1, 2'b00};
        prod1   = 40'(x1) * 40'(DIV146097_MUL);
        q0_next = prod1[39:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= n_next;
            q0_reg <= q0_next;
        end
    end

    // Correct the estimate by one where the remainder is too large.
    always_comb
    begin
        x2     = {n_reg + 23'd1, 2'b00};
        qm     = 25'(q0_reg) * 25'(DAYS_400Y);
        r2     = x2 - qm;
        q_next = (r2 >= 25'(DAYS_400Y)) ? q0_reg + 8'd1 : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg <= n_reg;
            q_reg  <= q_next;
        end
    end

    always_comb
    begin
        t3      = (10'(q_reg) + 10'd1) * 10'd3;
        a3      = t3[9:2];
        a2_next = {n2_reg, 2'b00} + 25'd3 + 25'({a3, 2'b00});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg <= a2_next;
        end
    end

    // Estimate the year a2 / 1461.
    always_comb
    begin
        prod4   = 38'(a2_reg) * 38'(DIV1461_MUL);
        y0_next = prod4[37:24];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2b_reg <= a2_reg;
            y0_reg  <= y0_next;
        end
    end

    // Correct the year, then day-in-year to the 5-month index b.
    always_comb
    begin
        rem     = a2b_reg - 25'(y0_reg) * 25'(DAYS_4Y);
        fix5    = (rem[11:0] >= 12'(DAYS_4Y));
        rem1    = fix5 ? rem[11:0] - 12'(DAYS_4Y) : rem[11:0];
        y5_next = y0_reg + 14'(fix5);
        b_next  = 11'(rem1[10:2]) * 11'd5 + 11'd2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y5_reg <= y5_next;
            b_reg  <= b_next;
        end
    end

    always_comb
    begin
        prod6   = 20'(b_reg) * 20'(DIV153_MUL);
        m0_next = prod6[19:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y6_reg <= y5_reg;
            b6_reg <= b_reg;
            m0_reg <= m0_next;
        end
    end

    // Correct the month, derive the day, fold months 13 and 14 forward.
    always_comb
    begin
        bm      = 11'(m0_reg) * 11'(DAYS_5M);
        r7      = b6_reg - bm;
        fix7    = (r7 >= 11'(DAYS_5M));
        rr      = fix7 ? r7 - 11'(DAYS_5M) : r7;
        m1      = m0_reg + 4'(fix7);
        prodd   = 15'(rr[7:0]) * 15'(DIV5_MUL);
        d7_next = prodd[14:10] + 5'd1;
        m3      = m1 + 4'd3;
        y7_next = y6_reg;
        m7_next = m3;
        if (m3 > 4'd12)
        begin
            m7_next = m3 - 4'd12;
            y7_next = y6_reg + 14'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y7_reg <= y7_next;
            m7_reg <= m7_next;
            d7_reg <= d7_next;
        end
    end

    assign res.zero  = zero_reg[DEPTH-1];
    assign res.year  = y7_reg;
    assign res.month = m7_reg;
    assign res.day   = d7_reg;

endmodule

`default_nettype wire

FILE: design/gregorian_mjd_converter.sv
// Top level of the Gregorian date / MJD converter: stream ports, valid
// pipeline, output select. Uses gmc_pkg, gmc_date2mjd, gmc_mjd2date.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s       | in  | s_tvalid, s_tready | s_tuser: action; s_tdata: date, MJD
//  m       | out | m_tvalid, m_tready | m_tuser: error;  m_tdata: MJD, date
//
// One item enters per cycle while s_tready is high; an accepted item moves
// through every stage to m_tvalid and leaves when m_tready is high, a depth
// of 7 set by the MJD-to-date path (three reciprocal divisions, each followed by
// a remainder correction, the last one sharing its stage with the day split).
// Reset clears only the valid bits; payload stages hold whatever they had.
// While the output item waits for m_tready, every stage holds and s_tready
// drops; an empty output register lets the pipeline advance.
`default_nettype none

module gregorian_mjd_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [47:0] s_tdata,  // year[13:0], month[17:14], day[22:18], mjd_in[44:23]
    input  wire logic        s_tuser,  // action (0 date to MJD, 1 MJD to date)
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata,  // mjd_out[23:0], year_out[37:24], month_out[41:38],
                                       // day_out[46:42]
    output      logic        m_tuser   // error
);
    import gmc_pkg::*;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] act_reg;
    logic             en;
    d2m_res_t         d_res;
    m2d_res_t         m_res;

    logic        error;
    logic [23:0] mjd_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;

    // Advance every stage unless the output item is stuck.
    assign en       = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // Carry the action beside the valid bit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg <= {act_reg[DEPTH-2:0], s_tuser};
        end
    end

    gmc_date2mjd u_date2mjd (
        .clk   (clk),
        .en    (en),
        .year  (s_tdata[13:0]),
        .month (s_tdata[17:14]),
        .day   (s_tdata[22:18]),
        .res   (d_res)
    );

    gmc_mjd2date u_mjd2date (
        .clk    (clk),
        .en     (en),
        .mjd_in (s_tdata[44:23]),
        .res    (m_res)
    );

    // Pick the finished path; zero all fields on a rejected item and
    // the fields that the chosen action does not produce.
    always_comb
    begin
        error     = 1'b0;
        mjd_out   = '0;
        year_out  = '0;
        month_out = '0;
        day_out   = '0;
        if (act_reg[DEPTH-1])
        begin
            error = m_res.zero;
            if (!m_res.zero)
            begin
                year_out  = m_res.year;
                month_out = m_res.month;
                day_out   = m_res.day;
            end
        end
        else
        begin
            error = !d_res.ok;
            if (d_res.ok)
            begin
                mjd_out = d_res.mjd;
            end
        end
    end

    assign m_tdata = {1'b0, day_out, month_out, year_out, mjd_out};
    assign m_tuser = error;

    // A good MJD-to-date result carries a real calendar month and day.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && act_reg[DEPTH-1] && !m_res.zero) |->
            (m_res.month >= 4'd1 && m_res.month <= 4'd12 &&
             m_res.day >= 5'd1 && m_res.day <= 5'd31))
        else $error("MJD-to-date produced an impossible month or day");

    // A stall freezes the whole valid pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid pipeline moved during a stall");

    // With the pipeline advancing, the valid bit of the next-to-last stage moves into the last.
    assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (vld_reg[DEPTH-1] == $past(vld_reg[DEPTH-2])))
        else $error("valid bit lost or invented between the last two stages");

endmodule

`default_nettype wire
